// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BUSY   = 2'd1;
   localparam logic [1:0] ST_BUSERR = 2'd2;
   localparam logic [1:0] ST_NACK   = 2'd3;

   localparam logic [7:0] BYTE_MSB  = 8'h80;
   localparam logic [7:0] READ_BIT  = 8'h01;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       byte_request;
      logic       active;
      logic       done_res;
      logic [1:0] status;
   } result_type;

endpackage

// ===== design/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4,
      PH_TXD, PH_TXH, PH_TXL, PH_TAR, PH_TAH, PH_TAL,
      PH_RXH, PH_RXL, PH_RAD, PH_RAH, PH_RAL,
      PH_WAIT, PH_SP1, PH_SP2, PH_SP3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_reg_ff, shift_reg_in;
   logic       read_mode_ff, read_mode_in;
   logic [7:0] pending_byte_ff, pending_byte_in;
   logic       pending_valid_ff, pending_valid_in;
   logic       pending_last_ff, pending_last_in;
   logic       current_last_ff, current_last_in;
   logic [1:0] result_status_ff, result_status_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [3:0] bit_inc;
   logic       rxv;
   logic [7:0] rxd;
   logic       done;
   logic [1:0] st;

   assign bit_inc = bit_count_ff + 4'd1;

   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_reg_in     = shift_reg_ff;
      read_mode_in     = read_mode_ff;
      pending_byte_in  = pending_byte_ff;
      pending_valid_in = pending_valid_ff;
      pending_last_in  = pending_last_ff;
      current_last_in  = current_last_ff;
      result_status_in = result_status_ff;
      scl_in           = scl_ff;
      sda_in           = sda_ff;
      rxv              = 1'b0;
      rxd              = 8'd0;
      done             = 1'b0;
      st               = ST_OK;

      if (item.command) begin
         if (!pending_valid_ff) begin
            pending_byte_in  = item.data_byte;
            pending_last_in  = item.last_byte;
            pending_valid_in = 1'b1;
         end
      end else begin
         if (phase_ff == PH_IDLE && pending_valid_ff) begin
            shift_reg_in     = pending_byte_ff;
            read_mode_in     = |(pending_byte_ff & READ_BIT);
            result_status_in = ST_OK;
            current_last_in  = pending_last_ff;
            pending_valid_in = 1'b0;
            bit_count_in     = 4'd0;
            phase_in         = PH_ST1;
         end else if (phase_ff == PH_WAIT && pending_valid_ff) begin
            current_last_in  = pending_last_ff;
            pending_valid_in = 1'b0;
            bit_count_in     = 4'd0;
            if (read_mode_ff) begin
               shift_reg_in = 8'd0;
               phase_in     = PH_RXH;
            end else begin
               shift_reg_in = pending_byte_ff;
               phase_in     = PH_TXD;
            end
         end

         case (phase_in)
            PH_IDLE, PH_WAIT: begin
            end
            PH_ST1: begin
               sda_in   = 1'b1;
               phase_in = PH_ST2;
            end
            PH_ST2: begin
               scl_in = 1'b1;
               if (!item.sda_in) begin
                  done     = 1'b1;
                  st       = ST_BUSY;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_ST3;
               end
            end
            PH_ST3: begin
               sda_in   = 1'b0;
               phase_in = PH_ST4;
            end
            PH_ST4: begin
               scl_in = 1'b0;
               if (item.sda_in) begin
                  done     = 1'b1;
                  st       = ST_BUSERR;
                  phase_in = PH_IDLE;
               end else begin
                  bit_count_in = 4'd0;
                  phase_in     = PH_TXD;
               end
            end
            PH_TXD: begin
               scl_in       = 1'b0;
               sda_in       = |(shift_reg_in & BYTE_MSB);
               shift_reg_in = {shift_reg_in[6:0], 1'b0};
               phase_in     = PH_TXH;
            end
            PH_TXH: begin
               scl_in   = 1'b1;
               phase_in = PH_TXL;
            end
            PH_TXL: begin
               scl_in       = 1'b0;
               bit_count_in = bit_inc;
               phase_in     = bit_inc[3] ? PH_TAR : PH_TXD;
            end
            PH_TAR: begin
               sda_in   = 1'b1;
               phase_in = PH_TAH;
            end
            PH_TAH: begin
               scl_in           = 1'b1;
               result_status_in = item.sda_in ? ST_NACK : ST_OK;
               phase_in         = PH_TAL;
            end
            PH_TAL: begin
               scl_in   = 1'b0;
               sda_in   = 1'b1;
               phase_in = (result_status_in == ST_NACK || current_last_in) ? PH_SP1 : PH_WAIT;
            end
            PH_RXH: begin
               sda_in       = 1'b1;
               scl_in       = 1'b1;
               shift_reg_in = {shift_reg_in[6:0], item.sda_in};
               phase_in     = PH_RXL;
            end
            PH_RXL: begin
               scl_in       = 1'b0;
               bit_count_in = bit_inc;
               if (bit_inc[3]) begin
                  rxv      = 1'b1;
                  rxd      = shift_reg_in;
                  phase_in = PH_RAD;
               end else begin
                  phase_in = PH_RXH;
               end
            end
            PH_RAD: begin
               sda_in   = current_last_in;
               phase_in = PH_RAH;
            end
            PH_RAH: begin
               scl_in   = 1'b1;
               phase_in = PH_RAL;
            end
            PH_RAL: begin
               scl_in = 1'b0;
               if (current_last_in) begin
                  phase_in = PH_SP1;
               end else begin
                  sda_in   = 1'b1;
                  phase_in = PH_WAIT;
               end
            end
            PH_SP1: begin
               sda_in   = 1'b0;
               phase_in = PH_SP2;
            end
            PH_SP2: begin
               scl_in   = 1'b1;
               phase_in = PH_SP3;
            end
            PH_SP3: begin
               sda_in   = 1'b1;
               done     = 1'b1;
               st       = result_status_in;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      result.scl_out      = scl_in;
      result.sda_out      = sda_in;
      result.rx_valid     = rxv;
      result.rx_data      = rxd;
      result.byte_request = (phase_in == PH_WAIT) && !pending_valid_in;
      result.active       = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.status       = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= 4'd0;
         shift_reg_ff     <= 8'd0;
         read_mode_ff     <= 1'b0;
         pending_valid_ff <= 1'b0;
         pending_last_ff  <= 1'b0;
         current_last_ff  <= 1'b0;
         result_status_ff <= ST_OK;
         scl_ff           <= 1'b1;
         sda_ff           <= 1'b1;
      end else if (fire) begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_reg_ff     <= shift_reg_in;
         read_mode_ff     <= read_mode_in;
         pending_valid_ff <= pending_valid_in;
         pending_last_ff  <= pending_last_in;
         current_last_ff  <= current_last_in;
         result_status_ff <= result_status_in;
         scl_ff           <= scl_in;
         sda_ff           <= sda_in;
      end
      if (fire) begin
         pending_byte_ff <= pending_byte_in;
      end
   end

endmodule

// ===== design/i2c_master_byte_transfer.sv =====
`timescale 1ns / 1ps

// Byte-wise I2C master. Every request beat is either a byte push (command 1) into a one-deep
// buffer or one bus tick (command 0) carrying the sampled SDA level, and every request beat
// yields exactly one response beat with the SCL/SDA drive levels and transfer status.
// Throughput is one beat per clock unless rsp_stall holds the response. A beat passes the
// request register and the response register with the combinational controller step in
// between. The first byte pushed while idle is the address (bit 0 = read).
// rsp_status with done_res: 0 ok, 1 bus busy, 2 bus error, 3 slave NACK.

module i2c_master_byte_transfer import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_out,
   output logic       rsp_sda_out,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_byte_request,
   output logic       rsp_active,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type step_result;
   logic       advance;
   logic       req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   i2cm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         item_ff.command   <= req_command;
         item_ff.data_byte <= req_data_byte;
         item_ff.last_byte <= req_last_byte;
         item_ff.sda_in    <= req_sda_in;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_out      = result_ff.scl_out;
   assign rsp_sda_out      = result_ff.sda_out;
   assign rsp_rx_valid     = result_ff.rx_valid;
   assign rsp_rx_data      = result_ff.rx_data;
   assign rsp_byte_request = result_ff.byte_request;
   assign rsp_active       = result_ff.active;
   assign rsp_done_res     = result_ff.done_res;
   assign rsp_status       = result_ff.status;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_active)
      else $error("transfer done while still active");

   a_req_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_request |-> rsp_active)
      else $error("byte request outside a transfer");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_done_res)
      else $error("status without done");

   a_rx_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> rsp_active && !rsp_done_res)
      else $error("received byte outside an active read");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with room downstream");

endmodule

// ===== bench/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_sda_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_scl_out,
   input  logic       rsp_sda_out,
   input  logic       rsp_rx_valid,
   input  logic [7:0] rsp_rx_data,
   input  logic       rsp_byte_request,
   input  logic       rsp_active,
   input  logic       rsp_done_res,
   input  logic [1:0] rsp_status,
   output int         fail_count,
   output int         exp_count
);

   typedef enum logic [4:0] {
      IDLE, START_A, START_B, START_C, START_D,
      TX_DATA, TX_HIGH, TX_LOW, ACK_REL, ACK_HIGH, ACK_LOW,
      RX_HIGH, RX_LOW, MACK_DRV, MACK_HIGH, MACK_LOW,
      WAIT_BYTE, STOP_A, STOP_B, STOP_C
   } bus_phase_type;

   bus_phase_type phase;
   logic [3:0] bit_cnt;
   logic [7:0] shreg;
   logic       rd_mode;
   logic [7:0] held_byte;
   logic       held_valid;
   logic       held_last;
   logic       cur_last;
   logic [1:0] xfer_status;
   logic       scl_lvl;
   logic       sda_lvl;

   result_type line_q[$];
   int         errors = 0;

   task automatic bus_step(input logic cmd, input logic [7:0] data, input logic last,
                           input logic sda, output result_type r);
      logic       rxv;
      logic [7:0] rxd;
      logic       done;
      logic [1:0] st;
      rxv  = 1'b0;
      rxd  = 8'h00;
      done = 1'b0;
      st   = ST_OK;
      if (cmd) begin
         if (!held_valid) begin
            held_byte  = data;
            held_last  = last;
            held_valid = 1'b1;
         end
      end else begin
         if (phase == IDLE && held_valid) begin
            shreg       = held_byte;
            rd_mode     = (held_byte & READ_BIT) != 8'h00;
            xfer_status = ST_OK;
            cur_last    = held_last;
            held_valid  = 1'b0;
            bit_cnt     = 4'd0;
            phase       = START_A;
         end else if (phase == WAIT_BYTE && held_valid) begin
            cur_last   = held_last;
            held_valid = 1'b0;
            bit_cnt    = 4'd0;
            if (rd_mode) begin
               shreg = 8'h00;
               phase = RX_HIGH;
            end else begin
               shreg = held_byte;
               phase = TX_DATA;
            end
         end
         case (phase)
            IDLE, WAIT_BYTE: ;
            START_A: begin
               sda_lvl = 1'b1;
               phase   = START_B;
            end
            START_B: begin
               scl_lvl = 1'b1;
               if (!sda) begin
                  done  = 1'b1;
                  st    = ST_BUSY;
                  phase = IDLE;
               end else begin
                  phase = START_C;
               end
            end
            START_C: begin
               sda_lvl = 1'b0;
               phase   = START_D;
            end
            START_D: begin
               scl_lvl = 1'b0;
               if (sda) begin
                  done  = 1'b1;
                  st    = ST_BUSERR;
                  phase = IDLE;
               end else begin
                  bit_cnt = 4'd0;
                  phase   = TX_DATA;
               end
            end
            TX_DATA: begin
               scl_lvl = 1'b0;
               sda_lvl = (shreg & BYTE_MSB) != 8'h00;
               shreg   = shreg << 1;
               phase   = TX_HIGH;
            end
            TX_HIGH: begin
               scl_lvl = 1'b1;
               phase   = TX_LOW;
            end
            TX_LOW: begin
               scl_lvl = 1'b0;
               bit_cnt = bit_cnt + 4'd1;
               phase   = (bit_cnt >= 4'd8) ? ACK_REL : TX_DATA;
            end
            ACK_REL: begin
               sda_lvl = 1'b1;
               phase   = ACK_HIGH;
            end
            ACK_HIGH: begin
               scl_lvl     = 1'b1;
               xfer_status = sda ? ST_NACK : ST_OK;
               phase       = ACK_LOW;
            end
            ACK_LOW: begin
               scl_lvl = 1'b0;
               sda_lvl = 1'b1;
               phase   = (xfer_status == ST_NACK || cur_last) ? STOP_A : WAIT_BYTE;
            end
            RX_HIGH: begin
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
               shreg   = {shreg[6:0], sda};
               phase   = RX_LOW;
            end
            RX_LOW: begin
               scl_lvl = 1'b0;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= 4'd8) begin
                  rxv   = 1'b1;
                  rxd   = shreg;
                  phase = MACK_DRV;
               end else begin
                  phase = RX_HIGH;
               end
            end
            MACK_DRV: begin
               sda_lvl = cur_last;
               phase   = MACK_HIGH;
            end
            MACK_HIGH: begin
               scl_lvl = 1'b1;
               phase   = MACK_LOW;
            end
            MACK_LOW: begin
               scl_lvl = 1'b0;
               if (cur_last) begin
                  phase = STOP_A;
               end else begin
                  sda_lvl = 1'b1;
                  phase   = WAIT_BYTE;
               end
            end
            STOP_A: begin
               sda_lvl = 1'b0;
               phase   = STOP_B;
            end
            STOP_B: begin
               scl_lvl = 1'b1;
               phase   = STOP_C;
            end
            STOP_C: begin
               sda_lvl = 1'b1;
               done    = 1'b1;
               st      = xfer_status;
               phase   = IDLE;
            end
            default: phase = IDLE;
         endcase
      end
      r.scl_out      = scl_lvl;
      r.sda_out      = sda_lvl;
      r.rx_valid     = rxv;
      r.rx_data      = rxd;
      r.byte_request = (phase == WAIT_BYTE) && !held_valid;
      r.active       = phase != IDLE;
      r.done_res     = done;
      r.status       = st;
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         phase       = IDLE;
         bit_cnt     = 4'd0;
         shreg       = 8'h00;
         rd_mode     = 1'b0;
         held_byte   = 8'h00;
         held_valid  = 1'b0;
         held_last   = 1'b0;
         cur_last    = 1'b0;
         xfer_status = ST_OK;
         scl_lvl     = 1'b1;
         sda_lvl     = 1'b1;
         line_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            bus_step(req_command, req_data_byte, req_last_byte, req_sda_in, want);
            line_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.scl_out      = rsp_scl_out;
            got.sda_out      = rsp_sda_out;
            got.rx_valid     = rsp_rx_valid;
            got.rx_data      = rsp_rx_data;
            got.byte_request = rsp_byte_request;
            got.active       = rsp_active;
            got.done_res     = rsp_done_res;
            got.status       = rsp_status;
            if (line_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected rsp beat", $realtime);
            end else begin
               want = line_q.pop_front();
               if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                   got.rx_valid !== want.rx_valid || got.rx_data !== want.rx_data ||
                   got.byte_request !== want.byte_request || got.active !== want.active ||
                   got.done_res !== want.done_res || got.status !== want.status) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: rsp mismatch (scl sda rxv rxd req act done st)",
                              $realtime);
                     $display("   exp %b %b %b %h %b %b %b %0d", want.scl_out, want.sda_out,
                              want.rx_valid, want.rx_data, want.byte_request, want.active,
                              want.done_res, want.status);
                     $display("   got %b %b %b %h %b %b %b %0d", got.scl_out, got.sda_out,
                              got.rx_valid, got.rx_data, got.byte_request, got.active,
                              got.done_res, got.status);
                  end
               end
            end
         end
      end
      exp_count  <= line_q.size();
      fail_count <= errors;
   end

endmodule

// ===== bench/tb_i2c_master_byte_transfer.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_byte_transfer;
   import i2cm_pkg::*;

   localparam int LIMIT        = 1000000;
   localparam int TARGET_ITEMS = 800;
   localparam int NO_NACK      = 99;

   localparam int F_NONE      = 0;
   localparam int F_BUSY      = 1;
   localparam int F_BUSERR    = 2;
   localparam int F_ADDR_NACK = 3;
   localparam int F_DATA_NACK = 4;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_command;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       req_sda_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_scl_out;
   logic       rsp_sda_out;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_data;
   logic       rsp_byte_request;
   logic       rsp_active;
   logic       rsp_done_res;
   logic [1:0] rsp_status;

   int fail_count;
   int exp_count;
   int cycles   = 0;
   int items    = 0;
   int rx_hold  = 0;
   bit tx_calm  = 1'b0;
   bit rx_calm  = 1'b0;

   i2c_master_byte_transfer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_byte_request (rsp_byte_request),
      .rsp_active       (rsp_active),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status)
   );

   i2cm_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_byte_request (rsp_byte_request),
      .rsp_active       (rsp_active),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .exp_count        (exp_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb_i2c_master_byte_transfer NOT OK");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rx_hold   <= 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            rsp_stall <= rx_hold > 1;
         end else if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 39) == 0)
               rx_calm = !rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 13);
            rx_hold   <= w;
            rsp_stall <= w != 0;
         end
      end
   end

   task automatic send_beat(input logic cmd, input logic [7:0] data, input logic last,
                            input logic sda, input bit counted);
      int gap;
      if ($urandom_range(0, 39) == 0)
         tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= data;
      req_last_byte <= last;
      req_sda_in    <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counted)
         items++;
   endtask

   task automatic tick(input logic sda);
      send_beat(1'b0, 8'($urandom), 1'($urandom), sda, 1'b1);
   endtask

   // a second push right after a push always lands on a full buffer
   task automatic push_byte(input logic [7:0] data, input logic last);
      send_beat(1'b1, data, last, 1'($urandom), 1'b1);
      if ($urandom_range(0, 7) == 0)
         send_beat(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (exp_count != 0) @(posedge clock);
   endtask

   task automatic run_transfer(input bit rd, input int nbytes, input int fault);
      logic [7:0] nxt;
      int         nack_at;
      int         nbits;
      int         early;
      bit         writing;
      bit         cont;
      push_byte({7'($urandom), rd}, nbytes == 0);
      tick(1'($urandom));
      if (fault == F_BUSY) begin
         tick(1'b0);
         return;
      end
      tick(1'b1);
      tick(1'($urandom));
      if (fault == F_BUSERR) begin
         tick(1'b1);
         return;
      end
      tick(1'b0);
      nack_at = NO_NACK;
      if (fault == F_ADDR_NACK)
         nack_at = -1;
      else if (fault == F_DATA_NACK && !rd && nbytes > 0)
         nack_at = $urandom_range(0, nbytes - 1);
      // segment -1 is the address, then one per data byte
      for (int s = -1; s < nbytes; s++) begin
         writing = (s < 0) || !rd;
         nbits   = writing ? 24 : 16;
         cont    = (s != nack_at) && (s < nbytes - 1);
         nxt     = 8'($urandom);
         early   = (cont && $urandom_range(0, 1) == 1) ? $urandom_range(1, nbits - 1) : -1;
         for (int i = 0; i < nbits; i++) begin
            if (i == early)
               push_byte(nxt, s + 1 == nbytes - 1);
            tick(1'($urandom));
         end
         tick(1'($urandom));
         tick(writing ? (s == nack_at) : 1'($urandom));
         tick(1'($urandom));
         if (!cont) begin
            repeat (3) tick(1'($urandom));
            return;
         end
         if (early < 0) begin
            repeat ($urandom_range(0, 2)) tick(1'($urandom));
            push_byte(nxt, s + 1 == nbytes - 1);
         end
      end
   endtask

   // random beats leave the block anywhere; pushes of a last byte with SDA high bring it
   // back to idle with the buffer empty
   task automatic noise_and_recover();
      repeat ($urandom_range(5, 20))
         send_beat(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      repeat (3) begin
         push_byte(8'($urandom), 1'b1);
         repeat (50) tick(1'b1);
      end
   endtask

   initial begin
      int  pick;
      int  f;
      int  nb;
      int  fault;
      bit  rd;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_command   <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      req_sda_in    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks, full-buffer push, busy bus, bus error
      tick(1'b0);
      tick(1'b1);
      send_beat(1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
      send_beat(1'b1, 8'hFF, 1'b1, 1'b1, 1'b0);
      tick(1'b1);
      tick(1'b0);
      send_beat(1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
      tick(1'b0);
      tick(1'b1);
      tick(1'b0);
      tick(1'b1);
      tick(1'b1);
      drain_results();

      while (items < TARGET_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            noise_and_recover();
         end else if (pick == 1) begin
            drain_results();
         end else begin
            rd = 1'($urandom);
            nb = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
            f  = $urandom_range(0, 11);
            if (f == 0)
               fault = F_BUSY;
            else if (f == 1)
               fault = F_BUSERR;
            else if (f == 2)
               fault = F_ADDR_NACK;
            else if (f <= 4 && !rd && nb > 0)
               fault = F_DATA_NACK;
            else
               fault = F_NONE;
            run_transfer(rd, nb, fault);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (exp_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && exp_count == 0) begin
         $display("tb_i2c_master_byte_transfer OK");
      end else begin
         $display("tb_i2c_master_byte_transfer NOT OK");
      end
      $finish;
   end

endmodule

// ===== i2c_master_byte_transfer.f =====
design/i2cm_pkg.sv
design/i2cm_engine.sv
design/i2c_master_byte_transfer.sv
bench/i2cm_checker.sv
bench/tb_i2c_master_byte_transfer.sv
